### src/rqba_pkg.sv
// Shared types, widths, constants and arithmetic steps for the bend-angle estimator.
`default_nettype none
package rqba_pkg;

	localparam int QUAT_WIDTH   = 16;
	localparam int INT_FRAC     = 24;
	localparam int QFRAC        = QUAT_WIDTH - 2;
	localparam int UP_SH        = (QFRAC <= INT_FRAC) ? (INT_FRAC - QFRAC) : 0;
	localparam int DN_SH        = (QFRAC > INT_FRAC) ? (QFRAC - INT_FRAC) : 0;
	localparam int QT_W         = QUAT_WIDTH + UP_SH;
	localparam int Q24_W        = INT_FRAC + 2;
	localparam int P1_W         = 2 * Q24_W + 2;
	localparam int R_W          = P1_W - INT_FRAC;
	localparam int P2_W         = 2 * R_W + 2;
	localparam int E_W          = P2_W - INT_FRAC;
	localparam int C_W          = INT_FRAC + 2;
	localparam int C_ONE        = 1 << INT_FRAC;
	localparam int RAD_W        = 2 * INT_FRAC + 1;
	localparam int SQ_W         = RAD_W + 2;
	localparam int S_W          = INT_FRAC + 1;
	localparam int CX_W         = INT_FRAC + 4;
	localparam int ANG_FRAC     = 16;
	localparam int BEND_FRAC    = 12;
	localparam int Z_W          = ANG_FRAC + 4;
	localparam int PHI_W        = ANG_FRAC + 2;
	localparam int CORDIC_STEPS = 17;
	localparam int CI_W         = $clog2(CORDIC_STEPS + 2);
	localparam int HALF_PI_Q16  = 102944;
	localparam int PI_Q16       = 205887;
	localparam int DIV_SH       = ANG_FRAC - BEND_FRAC;
	localparam int DIVD_W       = S_W + DIV_SH;
	localparam int NUM_W        = E_W + PHI_W + 1;
	localparam int MAG_W        = NUM_W - 1;
	localparam int RATE_W       = 16;
	localparam int OUT_W        = 16;
	localparam int OUT_MAX      = (1 << (OUT_W - 1)) - 1;
	localparam int OUT_MIN      = -(1 << (OUT_W - 1));
	localparam int QB           = OUT_W - 1;
	localparam int DK_W         = $clog2(QB);
	localparam int QUEUE_DEPTH  = 4;

	typedef logic signed [QUAT_WIDTH-1:0] quat_t;
	typedef logic signed [Q24_W-1:0] q24_t;
	typedef logic signed [R_W-1:0] rel_t;
	typedef logic signed [E_W-1:0] ent_t;
	typedef logic signed [RATE_W-1:0] rate_t;

	typedef struct packed {
		ent_t               r7;
		ent_t               r2;
		logic signed [C_W-1:0] c;
		logic [RAD_W-1:0]   rad;
		rate_t              rate_x;
		rate_t              rate_y;
	} item_t;

	typedef struct packed {
		logic [SQ_W-1:0] n;
		logic [SQ_W-1:0] res;
		logic [SQ_W-1:0] bt;
	} sq_t;

	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cx_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QB-1:0]    q;
	} dv_t;

	function automatic q24_t to_q24(input quat_t v);
		logic signed [QT_W-1:0] t;
		t = QT_W'(v);
		t = t <<< UP_SH;
		t = t >>> DN_SH;
		return Q24_W'(t);
	endfunction

	function automatic logic signed [2*Q24_W-1:0] mul_q(input q24_t a, input q24_t b);
		return a * b;
	endfunction

	function automatic logic signed [2*R_W-1:0] mul_r(input rel_t a, input rel_t b);
		return a * b;
	endfunction

	function automatic sq_t sqrt_step(input sq_t a);
		sq_t r;
		logic [SQ_W-1:0] t;
		r = a;
		t = a.res + a.bt;
		if (a.bt != '0) begin
			if (a.n >= t) begin
				r.n = a.n - t;
				r.res = (a.res >> 1) + a.bt;
			end else begin
				r.res = a.res >> 1;
			end
			r.bt = a.bt >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [Z_W-1:0] atan_q16(input logic [CI_W-1:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			CI_W'(0):  r = Z_W'(51472);
			CI_W'(1):  r = Z_W'(30386);
			CI_W'(2):  r = Z_W'(16055);
			CI_W'(3):  r = Z_W'(8150);
			CI_W'(4):  r = Z_W'(4091);
			CI_W'(5):  r = Z_W'(2047);
			CI_W'(6):  r = Z_W'(1024);
			CI_W'(7):  r = Z_W'(512);
			CI_W'(8):  r = Z_W'(256);
			CI_W'(9):  r = Z_W'(128);
			CI_W'(10): r = Z_W'(64);
			CI_W'(11): r = Z_W'(32);
			CI_W'(12): r = Z_W'(16);
			CI_W'(13): r = Z_W'(8);
			CI_W'(14): r = Z_W'(4);
			CI_W'(15): r = Z_W'(2);
			CI_W'(16): r = Z_W'(1);
			default:   r = '0;
		endcase
		return r;
	endfunction

	function automatic cx_t cordic_step(input cx_t a, input logic [CI_W-1:0] i);
		cx_t r;
		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dy;
		r = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (a.y > 0) begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + atan_q16(i);
		end else if (a.y < 0) begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - atan_q16(i);
		end
		return r;
	endfunction

	function automatic dv_t div_step(input dv_t a, input logic [DIVD_W-1:0] d,
			input logic [DK_W-1:0] k);
		dv_t r;
		logic [MAG_W-1:0] sh;
		r = a;
		sh = MAG_W'(d) << k;
		if (a.rem >= sh) begin
			r.rem = a.rem - sh;
			r.q[k] = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/rqba_front.sv
// Front pipeline: relative quaternion, rotation entries, clamp and sine radicand.
`default_nettype none
module rqba_front
	import rqba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire quat_t base_w,
	input  wire quat_t base_x,
	input  wire quat_t base_y,
	input  wire quat_t base_z,
	input  wire quat_t tip_w,
	input  wire quat_t tip_x,
	input  wire quat_t tip_y,
	input  wire quat_t tip_z,
	input  wire rate_t rate_x,
	input  wire rate_t rate_y,
	input  wire logic  q_full,
	output logic       push,
	output item_t      push_data
);

	logic en;
	logic v_s1, v_s2, v_s3;
	q24_t bw, bx, by, bz, tw, tx, ty, tz;
	logic signed [P1_W-1:0] sw, sx, sy, sz;
	rel_t rw_s1, rx_s1, ry_s1, rz_s1;
	rate_t ra_s1, rb_s1, ra_s2, rb_s2;
	logic signed [P2_W-1:0] s7, s2, s8;
	ent_t r7_s2, r2_s2, r8_s2;
	logic signed [C_W-1:0] c;
	logic signed [2*C_W-1:0] csq;
	item_t it_s3;

	assign en = !(v_s3 && q_full);
	assign in_ready = en;
	assign push = v_s3 && !q_full;
	assign push_data = it_s3;

	always_comb begin
		bw = to_q24(base_w);
		bx = to_q24(base_x);
		by = to_q24(base_y);
		bz = to_q24(base_z);
		tw = to_q24(tip_w);
		tx = to_q24(tip_x);
		ty = to_q24(tip_y);
		tz = to_q24(tip_z);
		sw = P1_W'(mul_q(bw, tw)) + P1_W'(mul_q(bx, tx)) + P1_W'(mul_q(by, ty))
			+ P1_W'(mul_q(bz, tz));
		sx = P1_W'(mul_q(bw, tx)) - P1_W'(mul_q(bx, tw)) - P1_W'(mul_q(by, tz))
			+ P1_W'(mul_q(bz, ty));
		sy = P1_W'(mul_q(bw, ty)) + P1_W'(mul_q(bx, tz)) - P1_W'(mul_q(by, tw))
			- P1_W'(mul_q(bz, tx));
		sz = P1_W'(mul_q(bw, tz)) - P1_W'(mul_q(bx, ty)) + P1_W'(mul_q(by, tx))
			- P1_W'(mul_q(bz, tw));
		s7 = P2_W'(mul_r(ry_s1, rz_s1)) + P2_W'(mul_r(rw_s1, rx_s1));
		s2 = P2_W'(mul_r(rx_s1, rz_s1)) + P2_W'(mul_r(rw_s1, ry_s1));
		s8 = P2_W'(mul_r(rw_s1, rw_s1)) - P2_W'(mul_r(rx_s1, rx_s1))
			- P2_W'(mul_r(ry_s1, ry_s1)) + P2_W'(mul_r(rz_s1, rz_s1));
		if (r8_s2 > E_W'(C_ONE)) begin
			c = C_W'(C_ONE);
		end else if (r8_s2 < -E_W'(C_ONE)) begin
			c = -C_W'(C_ONE);
		end else begin
			c = C_W'(r8_s2);
		end
		csq = c * c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rw_s1 <= R_W'(sw >>> INT_FRAC);
			rx_s1 <= R_W'(sx >>> INT_FRAC);
			ry_s1 <= R_W'(sy >>> INT_FRAC);
			rz_s1 <= R_W'(sz >>> INT_FRAC);
			ra_s1 <= rate_x;
			rb_s1 <= rate_y;
			r7_s2 <= E_W'((s7 <<< 1) >>> INT_FRAC);
			r2_s2 <= E_W'((s2 <<< 1) >>> INT_FRAC);
			r8_s2 <= E_W'(s8 >>> INT_FRAC);
			ra_s2 <= ra_s1;
			rb_s2 <= rb_s1;
			it_s3.r7 <= r7_s2;
			it_s3.r2 <= r2_s2;
			it_s3.c <= c;
			it_s3.rad <= {1'b1, {(2*INT_FRAC){1'b0}}} - RAD_W'(csq);
			it_s3.rate_x <= ra_s2;
			it_s3.rate_y <= rb_s2;
		end
	end

endmodule
`default_nettype wire

### src/rqba_queue.sv
// Short request queue between the front pipeline and the back sequencer.
`default_nettype none
module rqba_queue
	import rqba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_data,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_data,
	output logic       nonempty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### src/rqba_back.sv
// Back sequencer: square root, CORDIC angle, scale division and result register.
`default_nettype none
module rqba_back
	import rqba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_nonempty,
	input  wire item_t q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic signed [OUT_W-1:0] bend_u,
	output logic signed [OUT_W-1:0] bend_v,
	output rate_t      bend_u_rate,
	output rate_t      bend_v_rate
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQRT, ST_CORDIC, ST_MUL, ST_PREP, ST_DIV, ST_DONE
	} state_t;

	state_t state_q;
	item_t item_q;
	sq_t sq_q, sq1, sq2;
	cx_t cx_q, cx1, cx2, cx_init;
	logic [CI_W-1:0] ci_q, ci1;
	logic [S_W-1:0] s_q, s_new;
	logic [PHI_W-1:0] phi_q, phi_new;
	logic signed [NUM_W-1:0] num_u_q, num_v_q;
	dv_t du_q, dv_q, du1, du2, dv1, dv2;
	logic [DK_W-1:0] dk_q, dk1;
	logic [DIVD_W-1:0] dvs;
	logic [MAG_W-1:0] mag_u, mag_v;
	logic neg_u_q, neg_v_q, sat_u_q, sat_v_q;
	logic out_valid_q;
	logic signed [OUT_W-1:0] bend_u_q, bend_v_q;
	rate_t rate_u_q, rate_v_q;

	function automatic logic signed [OUT_W-1:0] bend_val(input ent_t e, input logic phi_zero,
			input logic s_zero, input logic neg, input logic sat, input logic [QB-1:0] q);
		ent_t sh;
		logic signed [OUT_W-1:0] r;
		sh = e >>> (INT_FRAC - BEND_FRAC);
		if (phi_zero) begin
			if (sh > E_W'(OUT_MAX)) begin
				r = OUT_W'(OUT_MAX);
			end else if (sh < E_W'(OUT_MIN)) begin
				r = OUT_W'(OUT_MIN);
			end else begin
				r = OUT_W'(sh);
			end
		end else if (s_zero) begin
			r = (e > 0) ? OUT_W'(OUT_MAX) : ((e < 0) ? OUT_W'(OUT_MIN) : '0);
		end else if (sat) begin
			r = neg ? OUT_W'(OUT_MIN) : OUT_W'(OUT_MAX);
		end else begin
			r = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		end
		return r;
	endfunction

	assign q_pop = (state_q == ST_IDLE) && q_nonempty;
	assign out_valid = out_valid_q;
	assign bend_u = bend_u_q;
	assign bend_v = bend_v_q;
	assign bend_u_rate = rate_u_q;
	assign bend_v_rate = rate_v_q;
	assign dvs = {s_q, {DIV_SH{1'b0}}};

	always_comb begin
		sq1 = sqrt_step(sq_q);
		sq2 = sqrt_step(sq1);
		s_new = S_W'(sq2.res);
		if (item_q.c < 0) begin
			cx_init.x = $signed({{(CX_W-S_W){1'b0}}, s_new});
			cx_init.y = -CX_W'(item_q.c);
			cx_init.z = Z_W'(HALF_PI_Q16);
		end else begin
			cx_init.x = CX_W'(item_q.c);
			cx_init.y = $signed({{(CX_W-S_W){1'b0}}, s_new});
			cx_init.z = '0;
		end
		ci1 = CI_W'(ci_q + 1'b1);
		cx1 = cordic_step(cx_q, ci_q);
		cx2 = (ci1 < CI_W'(CORDIC_STEPS)) ? cordic_step(cx1, ci1) : cx1;
		if (cx2.z < 0) begin
			phi_new = '0;
		end else if (cx2.z > Z_W'(PI_Q16)) begin
			phi_new = PHI_W'(PI_Q16);
		end else begin
			phi_new = PHI_W'(cx2.z);
		end
		mag_u = MAG_W'((num_u_q < 0) ? -num_u_q : num_u_q);
		mag_v = MAG_W'((num_v_q < 0) ? -num_v_q : num_v_q);
		dk1 = DK_W'(dk_q - 1'b1);
		du1 = div_step(du_q, dvs, dk_q);
		dv1 = div_step(dv_q, dvs, dk_q);
		du2 = (dk_q != '0) ? div_step(du1, dvs, dk1) : du1;
		dv2 = (dk_q != '0) ? div_step(dv1, dvs, dk1) : dv1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_nonempty) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq2.bt == '0) begin
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (CI_W'(ci_q + 2'd2) >= CI_W'(CORDIC_STEPS)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (dk_q <= DK_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_data;
				sq_q.n <= SQ_W'(q_data.rad);
				sq_q.res <= '0;
				sq_q.bt <= SQ_W'(1) << (2 * INT_FRAC);
			end
			ST_SQRT: begin
				sq_q <= sq2;
				s_q <= s_new;
				cx_q <= cx_init;
				ci_q <= '0;
			end
			ST_CORDIC: begin
				cx_q <= cx2;
				ci_q <= CI_W'(ci_q + 2'd2);
				phi_q <= phi_new;
			end
			ST_MUL: begin
				num_u_q <= NUM_W'(item_q.r7) * NUM_W'($signed({1'b0, phi_q}));
				num_v_q <= NUM_W'(item_q.r2) * NUM_W'($signed({1'b0, phi_q}));
			end
			ST_PREP: begin
				neg_u_q <= num_u_q < 0;
				neg_v_q <= num_v_q < 0;
				sat_u_q <= mag_u >= (MAG_W'(dvs) << QB);
				sat_v_q <= mag_v >= (MAG_W'(dvs) << QB);
				du_q <= '{rem: mag_u, q: '0};
				dv_q <= '{rem: mag_v, q: '0};
				dk_q <= DK_W'(QB - 1);
			end
			ST_DIV: begin
				du_q <= du2;
				dv_q <= dv2;
				dk_q <= DK_W'(dk_q - 2'd2);
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					bend_u_q <= bend_val(item_q.r7, phi_q == '0, s_q == '0, neg_u_q,
						sat_u_q, du_q.q);
					bend_v_q <= bend_val(item_q.r2, phi_q == '0, s_q == '0, neg_v_q,
						sat_v_q, dv_q.q);
					rate_u_q <= item_q.rate_x;
					rate_v_q <= item_q.rate_y;
				end
			end
			default: ;
		endcase
	end

	a_sine_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_PREP || state_q == ST_DIV || state_q == ST_DONE)
		|-> (s_q <= S_W'(C_ONE)))
		else $error("sine exceeds one");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sat_u_q && s_q != '0) |-> (du_q.rem < MAG_W'(dvs)))
		else $error("quotient remainder not below divisor");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DONE) |-> ($past(state_q) == ST_DIV))
		else $error("result stage entered out of order");

endmodule
`default_nettype wire

### src/relative_quat_to_bend_angles.sv
// Top level of the relative-quaternion to bend-angle estimator.
`default_nettype none
// Takes a base and a tip quaternion (Q1.14) and returns bend angles u and v in Q3.12
// radians from the relative rotation, with the tip rates passed along. The front
// pipeline accepts one request per cycle unless a full queue stalls it, and passes a
// request through its s1, s2 and s3 registers before it enters a four-entry queue, so
// from idle a burst of eight requests goes in back to back. The back end works on one
// request at a time: the square root (two root bits a cycle), the 17-step CORDIC (two
// steps a cycle), setup, the two parallel dividers (two quotient bits a cycle) and the
// result register; that iterative unit sets the sustained rate. A finished result waits
// in the output register while the next is computed.
module relative_quat_to_bend_angles
	import rqba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire quat_t base_w,
	input  wire quat_t base_x,
	input  wire quat_t base_y,
	input  wire quat_t base_z,
	input  wire quat_t tip_w,
	input  wire quat_t tip_x,
	input  wire quat_t tip_y,
	input  wire quat_t tip_z,
	input  wire rate_t rate_x,
	input  wire rate_t rate_y,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic signed [OUT_W-1:0] bend_u,
	output logic signed [OUT_W-1:0] bend_v,
	output rate_t      bend_u_rate,
	output rate_t      bend_v_rate
);

	logic q_full, q_nonempty, push, pop;
	item_t push_data, pop_data;

	rqba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base_w    (base_w),
		.base_x    (base_x),
		.base_y    (base_y),
		.base_z    (base_z),
		.tip_w     (tip_w),
		.tip_x     (tip_x),
		.tip_y     (tip_y),
		.tip_z     (tip_z),
		.rate_x    (rate_x),
		.rate_y    (rate_y),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	rqba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (q_nonempty)
	);

	rqba_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_data      (pop_data),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bend_u      (bend_u),
		.bend_v      (bend_v),
		.bend_u_rate (bend_u_rate),
		.bend_v_rate (bend_v_rate)
	);

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for relative_quat_to_bend_angles: table of directed requests and random requests
// checked field by field against tabled results or a bit-exact bend-angle predictor.
`default_nettype none
module testbench;
	import rqba_pkg::*;

	typedef struct {
		quat_t bq [4];
		quat_t tq [4];
		rate_t rx;
		rate_t ry;
	} pose_t;

	typedef struct {
		logic signed [15:0] u;
		logic signed [15:0] v;
		rate_t ur;
		rate_t vr;
	} bend_t;

	typedef struct {
		pose_t p;
		bit    known;
		bend_t b;
	} row_t;

	localparam int N_RANDOM = 1500;
	localparam int HOLD_CYCLES = 400;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	quat_t base_w, base_x, base_y, base_z, tip_w, tip_x, tip_y, tip_z;
	rate_t rate_x, rate_y;
	logic signed [OUT_W-1:0] bend_u, bend_v;
	rate_t bend_u_rate, bend_v_rate;

	bend_t pending_bends [$];
	int errors = 0;
	int sent = 0;
	bit sending_done = 0;

	relative_quat_to_bend_angles dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.base_w(base_w), .base_x(base_x), .base_y(base_y), .base_z(base_z),
		.tip_w(tip_w), .tip_x(tip_x), .tip_y(tip_y), .tip_z(tip_z),
		.rate_x(rate_x), .rate_y(rate_y), .out_valid(out_valid), .out_ready(out_ready),
		.bend_u(bend_u), .bend_v(bend_v), .bend_u_rate(bend_u_rate),
		.bend_v_rate(bend_v_rate)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n) bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint scale_bend(input longint e, input longint phi, input longint s);
		longint r;
		if (phi == 0) r = e >>> (INT_FRAC - BEND_FRAC);
		else if (s == 0) return (e > 0) ? OUT_MAX : ((e < 0) ? OUT_MIN : 0);
		else r = (e * phi) / (16 * s);
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return r;
	endfunction

	function automatic bend_t predict_bend(input pose_t p);
		longint b [4];
		longint t [4];
		longint rw, rx, ry, rz, r7, r2, r8, c, s, x, y, z, dx, dy;
		longint atan_tab [CORDIC_STEPS];
		bend_t o;
		atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		for (int i = 0; i < 4; i++) begin
			b[i] = (longint'(p.bq[i]) <<< UP_SH) >>> DN_SH;
			t[i] = (longint'(p.tq[i]) <<< UP_SH) >>> DN_SH;
		end
		rw = (b[0]*t[0] + b[1]*t[1] + b[2]*t[2] + b[3]*t[3]) >>> INT_FRAC;
		rx = (b[0]*t[1] - b[1]*t[0] - b[2]*t[3] + b[3]*t[2]) >>> INT_FRAC;
		ry = (b[0]*t[2] + b[1]*t[3] - b[2]*t[0] - b[3]*t[1]) >>> INT_FRAC;
		rz = (b[0]*t[3] - b[1]*t[2] + b[2]*t[1] - b[3]*t[0]) >>> INT_FRAC;
		r7 = (2 * (ry*rz + rw*rx)) >>> INT_FRAC;
		r2 = (2 * (rx*rz + rw*ry)) >>> INT_FRAC;
		r8 = (rw*rw - rx*rx - ry*ry + rz*rz) >>> INT_FRAC;
		c = r8;
		if (c > C_ONE) c = C_ONE;
		if (c < -C_ONE) c = -C_ONE;
		s = longint'(int_sqrt(longint'(C_ONE) * C_ONE - c * c));
		if (c < 0) begin
			x = s; y = -c; z = HALF_PI_Q16;
		end else begin
			x = c; y = s; z = 0;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx; y = y - dy; z = z + atan_tab[i];
			end else if (y < 0) begin
				x = x - dx; y = y + dy; z = z - atan_tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > PI_Q16) z = PI_Q16;
		o.u = 16'(scale_bend(r7, z, s));
		o.v = 16'(scale_bend(r2, z, s));
		o.ur = p.rx;
		o.vr = p.ry;
		return o;
	endfunction

	function automatic pose_t make_pose(input int bw, bx, by, bz, tw, tx, ty, tz, rx, ry);
		pose_t p;
		p.bq = '{quat_t'(bw), quat_t'(bx), quat_t'(by), quat_t'(bz)};
		p.tq = '{quat_t'(tw), quat_t'(tx), quat_t'(ty), quat_t'(tz)};
		p.rx = rate_t'(rx);
		p.ry = rate_t'(ry);
		return p;
	endfunction

	function automatic int rand_comp();
		return $urandom_range(32768) - 16384;
	endfunction

	function automatic void unit_quat(output quat_t q [4]);
		real a [4];
		real n;
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			a[i] = real'(rand_comp());
			n = n + a[i] * a[i];
		end
		if (n == 0.0) begin
			a[0] = 1.0; n = 1.0;
		end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++) q[i] = quat_t'($rtoi(a[i] / n * 16384.0));
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int kind;
		int ex [5];
		ex = '{-32768, -16384, 0, 16384, 32767};
		kind = $urandom_range(9);
		unit_quat(p.bq);
		case (kind)
			0, 1, 2, 3: unit_quat(p.tq);
			4, 5: for (int i = 0; i < 4; i++)
				p.tq[i] = quat_t'(int'(p.bq[i]) + $urandom_range(64) - 32);
			6: begin
				p.tq = '{-p.bq[1], p.bq[0], p.bq[3], -p.bq[2]};
				for (int i = 0; i < 4; i++) p.tq[i] = p.tq[i] + quat_t'($urandom_range(4) - 2);
			end
			7, 8: for (int i = 0; i < 4; i++) begin
				p.bq[i] = quat_t'($urandom);
				p.tq[i] = quat_t'($urandom);
			end
			default: for (int i = 0; i < 4; i++) begin
				p.bq[i] = quat_t'(ex[$urandom_range(4)]);
				p.tq[i] = quat_t'(ex[$urandom_range(4)]);
			end
		endcase
		p.rx = rate_t'($urandom);
		p.ry = rate_t'($urandom);
		return p;
	endfunction

	task automatic send_request(input pose_t p, input bit known, input bend_t b);
		int gap;
		gap = (((sent / 150) % 3) == 0) ? 0 : $urandom_range(8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		base_w <= p.bq[0]; base_x <= p.bq[1]; base_y <= p.bq[2]; base_z <= p.bq[3];
		tip_w <= p.tq[0]; tip_x <= p.tq[1]; tip_y <= p.tq[2]; tip_z <= p.tq[3];
		rate_x <= p.rx; rate_y <= p.ry;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_bends.push_back(known ? b : predict_bend(p));
		sent++;
	endtask

	initial begin
		row_t rows [$];
		row_t r;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{base_w, base_x, base_y, base_z, tip_w, tip_x, tip_y, tip_z} = '0;
		rate_x = '0;
		rate_y = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		r.known = 1;
		r.p = make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0);
		r.b = '{0, 0, 0, 0}; rows.push_back(r);
		r.p = make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 32767, -32768);
		r.b = '{0, 0, 32767, -32768}; rows.push_back(r);
		r.p = make_pose(16384, 0, 0, 0, -16384, 0, 0, 0, -32768, 32767);
		r.b = '{0, 0, -32768, 32767}; rows.push_back(r);
		r.p = make_pose(0, 0, 0, 0, 0, 0, 0, 0, 1, -1);
		r.b = '{0, 0, 1, -1}; rows.push_back(r);
		r.p = make_pose(16384, 0, 0, 0, 0, 16384, 0, 0, 5, 6);
		r.b = '{0, 0, 5, 6}; rows.push_back(r);
		r.known = 0;
		rows.push_back('{make_pose(16384, 0, 0, 0, 11585, 11585, 0, 0, 7, 8), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 11585, 0, 11585, 0, 9, 10), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 11585, 0, 0, 11585, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 16383, 30, -20, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 16384, 1, 1, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 2, 16383, 0, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 2, 0, -16383, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 0, 0, 0, 0, 11585, 11585, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, 0, 0), 0, r.b});
		rows.push_back('{make_pose(32767, 32767, 32767, 32767,
			-32768, 32767, -32768, 32767, 0, 0), 0, r.b});
		rows.push_back('{make_pose(32767, -32768, 0, 32767, 0, 32767, -32768, 0, 0, 0), 0, r.b});
		rows.push_back('{make_pose(16384, 16384, 16384, 16384, 16384, -16384, 16384, -16384,
			0, 0), 0, r.b});
		rows.push_back('{make_pose(1000, -2000, 3000, -4000, 5, 6, 7, 8, 0, 0), 0, r.b});
		rows.push_back('{make_pose(8192, 8192, 8192, 8192, 8192, 8192, -8192, -8192, 0, 0),
			0, r.b});
		foreach (rows[i]) send_request(rows[i].p, rows[i].known, rows[i].b);
		repeat (N_RANDOM) send_request(random_pose(), 0, r.b);
		in_valid <= 1'b0;
		sending_done = 1;
	end

	initial begin
		int w;
		int results;
		bit held;
		results = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (!held && results == 100) begin
				held = 1;
				w = HOLD_CYCLES;
			end else begin
				w = (((results / 120) % 3) == 1) ? 0 : $urandom_range(8);
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results++;
		end
	end

	always @(posedge clk) begin
		bend_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bends.size() == 0) begin
				$display("%0t: unexpected result u=%0d v=%0d", $time, bend_u, bend_v);
				errors++;
			end else begin
				e = pending_bends.pop_front();
				if (bend_u !== e.u) begin
					$display("%0t: bend_u expected %0d actual %0d", $time, e.u, bend_u);
					errors++;
				end
				if (bend_v !== e.v) begin
					$display("%0t: bend_v expected %0d actual %0d", $time, e.v, bend_v);
					errors++;
				end
				if (bend_u_rate !== e.ur) begin
					$display("%0t: bend_u_rate expected %0d actual %0d", $time, e.ur,
						bend_u_rate);
					errors++;
				end
				if (bend_v_rate !== e.vr) begin
					$display("%0t: bend_v_rate expected %0d actual %0d", $time, e.vr,
						bend_v_rate);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (sending_done);
		while (pending_bends.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_bends.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
